@@ rtl/npcs_pkg.sv @@
`default_nettype none
package npcs_pkg;

  localparam int CH_W      = 16;
  localparam int IDX_W     = 8;
  localparam int DEPTH     = 256;
  localparam int CNT_W     = 9;
  localparam int W_W       = 16;
  localparam int LIMB_W    = 32;
  localparam int OPND_W    = 3 * LIMB_W;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int DIST_W    = 176;
  localparam int ALIGN     = 4 * CH_W + 34;
  localparam int RATIO_W   = CH_W + 1;
  localparam int DIVC_W    = 5;
  localparam int STEP_W    = 4;
  localparam int REG_IDX_W = 3;

  localparam logic [18:0] TWO_PI_Q3_16 = 19'd411775;

  localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WA    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WB    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WC    = 3'd4;

  typedef enum logic [3:0] {
    OP_DW0, OP_DW1, OP_DW2, OP_SQ1, OP_SQ3, OP_HUE1, OP_HUE2, OP_HUE3, OP_HUE4
  } op_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_PLAIN, ACC_ALIGN
  } acc_t;

  typedef struct packed {
    op_t  op;
    acc_t acc;
    logic last;
  } prog_t;

  typedef struct packed {
    logic wr_entry;
    logic lookup_start;
    logic prep;
    logic mul_start;
    op_t  mul_op;
    acc_t acc;
    logic cmp;
    logic k_inc;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mul_busy;
    logic last_entry;
    logic count_zero;
  } status_t;

  // micro program of one distance evaluation
  function automatic prog_t prog_step(input logic mode, input logic [STEP_W-1:0] step);
    prog_t p;
    p = '{op: OP_SQ1, acc: ACC_NONE, last: 1'b1};
    if (!mode) begin
      case (step)
        4'd0: p = '{op: OP_DW0, acc: ACC_NONE,  last: 1'b0};
        4'd1: p = '{op: OP_SQ1, acc: ACC_PLAIN, last: 1'b0};
        4'd2: p = '{op: OP_DW1, acc: ACC_NONE,  last: 1'b0};
        4'd3: p = '{op: OP_SQ1, acc: ACC_PLAIN, last: 1'b0};
        4'd4: p = '{op: OP_DW2, acc: ACC_NONE,  last: 1'b0};
        4'd5: p = '{op: OP_SQ1, acc: ACC_PLAIN, last: 1'b1};
        default: p = '{op: OP_SQ1, acc: ACC_NONE, last: 1'b1};
      endcase
    end else begin
      case (step)
        4'd0: p = '{op: OP_DW0,  acc: ACC_NONE,  last: 1'b0};
        4'd1: p = '{op: OP_SQ1,  acc: ACC_ALIGN, last: 1'b0};
        4'd2: p = '{op: OP_DW1,  acc: ACC_NONE,  last: 1'b0};
        4'd3: p = '{op: OP_SQ1,  acc: ACC_ALIGN, last: 1'b0};
        4'd4: p = '{op: OP_HUE1, acc: ACC_NONE,  last: 1'b0};
        4'd5: p = '{op: OP_HUE2, acc: ACC_NONE,  last: 1'b0};
        4'd6: p = '{op: OP_HUE3, acc: ACC_NONE,  last: 1'b0};
        4'd7: p = '{op: OP_HUE4, acc: ACC_NONE,  last: 1'b0};
        4'd8: p = '{op: OP_SQ3,  acc: ACC_PLAIN, last: 1'b1};
        default: p = '{op: OP_SQ1, acc: ACC_NONE, last: 1'b1};
      endcase
    end
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/npcs_mul.sv @@
`default_nettype none
module npcs_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [npcs_pkg::OPND_W-1:0] x,
  input  wire logic [npcs_pkg::OPND_W-1:0] y,
  input  wire logic [1:0]                  xl,
  input  wire logic [1:0]                  yl,
  output logic                             busy,
  output logic [npcs_pkg::PROD_W-1:0]      p
);

  logic [npcs_pkg::OPND_W-1:0]     xr, yr;
  logic [1:0]                      xn, yn, i, j;
  logic                            issuing, pv;
  logic [2*npcs_pkg::LIMB_W-1:0]   pp;
  logic [2:0]                      ppsh;
  logic [npcs_pkg::LIMB_W-1:0]     xa, ya;

  function automatic logic [npcs_pkg::LIMB_W-1:0] limb(
    input logic [npcs_pkg::OPND_W-1:0] v, input logic [1:0] n);
    logic [npcs_pkg::LIMB_W-1:0] r;
    case (n)
      2'd0:    r = v[31:0];
      2'd1:    r = v[63:32];
      2'd2:    r = v[95:64];
      default: r = '0;
    endcase
    return r;
  endfunction

  assign xa   = limb(xr, i);
  assign ya   = limb(yr, j);
  assign busy = issuing | pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      pv      <= 1'b0;
    end else if (start) begin
      issuing <= 1'b1;
      pv      <= 1'b0;
      xr      <= x;
      yr      <= y;
      xn      <= xl;
      yn      <= yl;
      i       <= 2'd0;
      j       <= 2'd0;
      p       <= '0;
    end else begin
      pv <= issuing;
      if (issuing) begin
        pp   <= xa * ya;
        ppsh <= {1'b0, i} + {1'b0, j};
        if (j == yn - 2'd1) begin
          j <= 2'd0;
          if (i == xn - 2'd1) issuing <= 1'b0;
          else i <= i + 2'd1;
        end else begin
          j <= j + 2'd1;
        end
      end
      if (pv) begin
        p <= p + ({{(npcs_pkg::PROD_W-2*npcs_pkg::LIMB_W){1'b0}}, pp} << {ppsh, 5'b0});
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/npcs_dp.sv @@
`default_nettype none
module npcs_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire npcs_pkg::cmd_t                cmd,
  output npcs_pkg::status_t                  status,
  input  wire logic                          mode,
  input  wire logic [npcs_pkg::CNT_W-1:0]    count,
  input  wire logic [npcs_pkg::W_W-1:0]      wa,
  input  wire logic [npcs_pkg::W_W-1:0]      wb,
  input  wire logic [npcs_pkg::W_W-1:0]      wc,
  input  wire logic [npcs_pkg::IDX_W-1:0]    entry_index,
  input  wire logic [npcs_pkg::CH_W-1:0]     chan_a,
  input  wire logic [npcs_pkg::CH_W-1:0]     chan_b,
  input  wire logic [npcs_pkg::CH_W-1:0]     chan_c,
  output logic [npcs_pkg::IDX_W-1:0]         best
);

  localparam int CW = npcs_pkg::CH_W;

  logic [3*CW-1:0]                 mem [npcs_pkg::DEPTH];
  logic [3*CW-1:0]                 rd;
  logic [CW-1:0]                   ca, cb, cc;
  logic [npcs_pkg::IDX_W-1:0]      k;
  logic [CW-1:0]                   pa, pb, pc;
  logic [CW-1:0]                   da_w, db_w, dc_w, rmin_w, rmax_w, dh_raw, dh_w;
  logic [CW-1:0]                   da, db, dc, rmax, dh;
  logic [CW:0]                     rsum;
  logic [CW:0]                     rem;
  logic [npcs_pkg::RATIO_W-1:0]    q, ratio;
  logic [npcs_pkg::DIVC_W-1:0]     divc;
  logic [npcs_pkg::OPND_W-1:0]     mx, my;
  logic [1:0]                      mxl, myl;
  logic                            mbusy;
  logic [npcs_pkg::PROD_W-1:0]     mp;
  logic [npcs_pkg::DIST_W-1:0]     dsum, best_d;

  assign pa = rd[3*CW-1:2*CW];
  assign pb = rd[2*CW-1:CW];
  assign pc = rd[CW-1:0];

  // per-entry operands from the palette word
  always_comb begin
    da_w   = (ca > pa) ? ca - pa : pa - ca;
    db_w   = (cb > pb) ? cb - pb : pb - cb;
    dc_w   = (cc > pc) ? cc - pc : pc - cc;
    rmin_w = (cb < pb) ? cb : pb;
    rmax_w = (cb < pb) ? pb : cb;
    dh_raw = pc - cc;
    dh_w   = dh_raw[CW-1] ? CW'((17'd1 << CW) - {1'b0, dh_raw}) : dh_raw;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) mem[entry_index] <= {chan_a, chan_b, chan_c};
    rd <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_start) begin
      ca <= chan_a;
      cb <= chan_b;
      cc <= chan_c;
    end
    if (cmd.prep) begin
      da   <= da_w;
      db   <= db_w;
      dc   <= dc_w;
      rmax <= rmax_w;
      dh   <= dh_w;
      rsum <= {1'b0, rmin_w} + {1'b0, rmax_w};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.lookup_start) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
  end

  // restoring divider for the chroma ratio, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      divc <= '0;
    end else if (cmd.prep) begin
      divc <= npcs_pkg::DIVC_W'(npcs_pkg::RATIO_W);
      rem  <= {1'b0, rmin_w};
      q    <= '0;
    end else if (divc != '0) begin
      divc <= divc - 1'b1;
      if (rem >= {1'b0, rmax}) begin
        rem <= (rem - {1'b0, rmax}) << 1;
        q   <= {q[npcs_pkg::RATIO_W-2:0], 1'b1};
      end else begin
        rem <= rem << 1;
        q   <= {q[npcs_pkg::RATIO_W-2:0], 1'b0};
      end
    end
  end

  assign ratio = (rmax == '0) ? npcs_pkg::RATIO_W'(1 << CW) : q;

  // operand select for the shared multiplier
  always_comb begin
    mx  = '0;
    my  = '0;
    mxl = 2'd1;
    myl = 2'd1;
    case (cmd.mul_op)
      npcs_pkg::OP_DW0: begin
        mx = npcs_pkg::OPND_W'(mode ? db : da);
        my = npcs_pkg::OPND_W'(mode ? wb : wa);
      end
      npcs_pkg::OP_DW1: begin
        mx = npcs_pkg::OPND_W'(mode ? da : db);
        my = npcs_pkg::OPND_W'(mode ? wc : wb);
      end
      npcs_pkg::OP_DW2: begin
        mx = npcs_pkg::OPND_W'(dc);
        my = npcs_pkg::OPND_W'(wc);
      end
      npcs_pkg::OP_SQ1: begin
        mx = mp[npcs_pkg::OPND_W-1:0];
        my = mp[npcs_pkg::OPND_W-1:0];
      end
      npcs_pkg::OP_SQ3: begin
        mx  = mp[npcs_pkg::OPND_W-1:0];
        my  = mp[npcs_pkg::OPND_W-1:0];
        mxl = 2'd3;
        myl = 2'd3;
      end
      npcs_pkg::OP_HUE1: begin
        mx = npcs_pkg::OPND_W'(dh);
        my = npcs_pkg::OPND_W'(npcs_pkg::TWO_PI_Q3_16);
      end
      npcs_pkg::OP_HUE2: begin
        mx  = mp[npcs_pkg::OPND_W-1:0];
        my  = npcs_pkg::OPND_W'(wa);
        mxl = 2'd2;
      end
      npcs_pkg::OP_HUE3: begin
        mx  = mp[npcs_pkg::OPND_W-1:0];
        my  = npcs_pkg::OPND_W'(ratio);
        mxl = 2'd2;
      end
      npcs_pkg::OP_HUE4: begin
        mx  = mp[npcs_pkg::OPND_W-1:0];
        my  = npcs_pkg::OPND_W'(rsum);
        mxl = 2'd3;
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  npcs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .xl    (mxl),
    .yl    (myl),
    .busy  (mbusy),
    .p     (mp)
  );

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dsum <= '0;
    end else begin
      case (cmd.acc)
        npcs_pkg::ACC_PLAIN: dsum <= dsum + mp[npcs_pkg::DIST_W-1:0];
        npcs_pkg::ACC_ALIGN:
          dsum <= dsum + (npcs_pkg::DIST_W'(mp[2*npcs_pkg::LIMB_W-1:0]) << npcs_pkg::ALIGN);
        default: dsum <= dsum;
      endcase
    end
  end

  // strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (cmd.lookup_start) begin
      best <= '0;
    end else if (cmd.cmp && (k == '0 || dsum < best_d)) begin
      best   <= k;
      best_d <= dsum;
    end
  end

  assign status.div_busy   = (divc != '0);
  assign status.mul_busy   = mbusy;
  assign status.last_entry = (({1'b0, k} + 9'd1) == count);
  assign status.count_zero = (count == '0);

endmodule
`default_nettype wire

@@ rtl/npcs_ctrl.sv @@
`default_nettype none
module npcs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              req_type,
  input  wire logic              mode,
  input  wire npcs_pkg::status_t status,
  output npcs_pkg::cmd_t         cmd,
  output logic                   busy,
  output logic                   done
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_ISSUE = 8'b0001_0000,
    S_MULW  = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                       state, state_next;
  logic [npcs_pkg::STEP_W-1:0]  step, step_next;
  npcs_pkg::prog_t              pr;
  logic                         accept;

  assign pr     = npcs_pkg::prog_step(mode, step);
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    state_next       = state;
    step_next        = step;
    cmd              = '0;
    cmd.mul_op       = pr.op;
    cmd.acc          = npcs_pkg::ACC_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!req_type) begin
            cmd.wr_entry = 1'b1;
          end else begin
            cmd.lookup_start = 1'b1;
            state_next = status.count_zero ? S_DONE : S_READ;
          end
        end
      end
      S_READ: state_next = S_PREP;
      S_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = '0;
        state_next = mode ? S_DIV : S_ISSUE;
      end
      S_DIV: if (!status.div_busy) state_next = S_ISSUE;
      S_ISSUE: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MULW;
      end
      S_MULW: begin
        if (!status.mul_busy) begin
          cmd.acc = pr.acc;
          if (pr.last) begin
            state_next = S_CMP;
          end else begin
            step_next  = step + 1'b1;
            state_next = S_ISSUE;
          end
        end
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (status.last_entry) begin
          state_next = S_DONE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nearest_palette_color_search_top.sv @@
// palette write: a new item may follow in the next cycle, no result
// lookup: every scanned entry passes through the shared 32x32 multiplier, stepping limb by limb,
//   and, in lch mode, first through the 17-step ratio divider
// result strobe in the cycle after the last entry's compare, or in the cycle after the transfer with zero entries
// sync reset clears control and config registers; palette contents are not cleared
// the receiver cannot stall: done is a one-cycle strobe
`default_nettype none
module nearest_palette_color_search_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // item channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                req_type,
  input  wire logic [npcs_pkg::IDX_W-1:0]          entry_index,
  input  wire logic [npcs_pkg::CH_W-1:0]           chan_a,
  input  wire logic [npcs_pkg::CH_W-1:0]           chan_b,
  input  wire logic [npcs_pkg::CH_W-1:0]           chan_c,
  // config write port
  input  wire logic                                cfg_we,
  input  wire logic [npcs_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [npcs_pkg::W_W-1:0]            cfg_data,
  // result
  output logic                                     done,
  output logic [npcs_pkg::IDX_W-1:0]               color_index
);

  // config registers
  logic                          distance_mode;
  logic [npcs_pkg::CNT_W-1:0]    palette_count;
  logic [npcs_pkg::W_W-1:0]      weight_a, weight_b, weight_c;
  logic [npcs_pkg::CNT_W-1:0]    count_eff;

  npcs_pkg::cmd_t    cmd;
  npcs_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode <= 1'b0;
      palette_count <= '0;
      weight_a      <= 16'd4096;
      weight_b      <= 16'd4096;
      weight_c      <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        npcs_pkg::REG_MODE:  distance_mode <= cfg_data[0];
        npcs_pkg::REG_COUNT: palette_count <= cfg_data[npcs_pkg::CNT_W-1:0];
        npcs_pkg::REG_WA:    weight_a      <= cfg_data;
        npcs_pkg::REG_WB:    weight_b      <= cfg_data;
        npcs_pkg::REG_WC:    weight_c      <= cfg_data;
        default: ;
      endcase
    end
  end

  // count saturates at the palette depth
  assign count_eff = (palette_count > npcs_pkg::CNT_W'(npcs_pkg::DEPTH))
                   ? npcs_pkg::CNT_W'(npcs_pkg::DEPTH) : palette_count;

  npcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .mode     (distance_mode),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  npcs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .mode        (distance_mode),
    .count       (count_eff),
    .wa          (weight_a),
    .wb          (weight_b),
    .wc          (weight_c),
    .entry_index (entry_index),
    .chan_a      (chan_a),
    .chan_b      (chan_b),
    .chan_c      (chan_c),
    .best        (color_index)
  );

  // a lookup transfer always occupies the block
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type) |=> busy)
    else $error("lookup transfer did not raise busy");

  // palette writes complete at once
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !req_type) |=> !busy)
    else $error("palette write held the block");

  // result strobe lasts one cycle and frees the block
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire
